// File: rtl/rfr_pkg.sv
// Shared types, codes and CRC step functions for the referee frame receiver.
package rfr_pkg;

    // Frame start byte and CRC seeds
    localparam logic [7:0]  SOF_BYTE     = 8'hA5;
    localparam logic [7:0]  HDR_CRC_SEED = 8'hFF;
    localparam logic [15:0] CRC16_INIT   = 16'hFFFF;
    localparam logic [7:0]  CRC8_POLY    = 8'h8C;
    localparam logic [15:0] CRC16_POLY   = 16'h8408;

    // Position of the header CRC-8 byte, after start byte, two length bytes and sequence
    localparam int unsigned HDR_LAST = 4;

    // Known command ids
    localparam logic [15:0] CMD_GAME_STATUS  = 16'h0201;
    localparam logic [15:0] CMD_POWER_HEAT   = 16'h0202;
    localparam logic [15:0] CMD_ROBOT_HURT   = 16'h0206;
    localparam logic [15:0] CMD_SHOOT_DATA   = 16'h0207;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_CMD     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_TAIL    = 3'd4
    } phase_t;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_IDLE = 1'b1
    } action_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HDR_CRC   = 2'd1,
        ST_TAIL_CRC  = 2'd2,
        ST_LEN_LARGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CLS_OTHER       = 3'd0,
        CLS_GAME_STATUS = 3'd1,
        CLS_ROBOT_HURT  = 3'd2,
        CLS_SHOOT_DATA  = 3'd3,
        CLS_POWER_HEAT  = 3'd4
    } class_t;

    // Reflected CRC-8 update over one byte
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Reflected CRC-16 update over one byte
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Map a command id onto its class code
    function automatic class_t classify(input logic [15:0] id);
        class_t cls;
        case (id)
            CMD_GAME_STATUS: cls = CLS_GAME_STATUS;
            CMD_ROBOT_HURT:  cls = CLS_ROBOT_HURT;
            CMD_SHOOT_DATA:  cls = CLS_SHOOT_DATA;
            CMD_POWER_HEAT:  cls = CLS_POWER_HEAT;
            default:         cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

// File: rtl/rfr_in_if.sv
// Input channel: one received byte or a line idle marker per item.
interface rfr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// File: rtl/rfr_out_if.sv
// Output channel: a payload byte or a frame end status per item.
interface rfr_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_offset;
    logic [15:0] command_id;
    logic [15:0] frame_length;
    logic [1:0]  frame_status;
    logic [2:0]  command_class;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_offset, output command_id, output frame_length,
                    output frame_status, output command_class, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_offset, input command_id, input frame_length,
                    input frame_status, input command_class, output ready);
endinterface

// File: rtl/referee_frame_receiver.sv
// Referee serial frame receiver: start hunt, header and tail CRC checks, payload stream.
//
// Usage:
//   in_ch carries one item per received byte (action 0) or a line idle marker
//   (action 1) which abandons any partial frame without a result.
//   out_ch carries at most one item per input item: each payload byte as it
//   arrives (result_kind 0), and one status item at frame end (result_kind 1).
//   A status item ends the frame on a bad header CRC, an over-long length or
//   after the two tail CRC bytes. Drop a frame's payload unless its status is 0.
//   Output: a result is registered onto out_ch in the cycle after its input item is taken.
//   Throughput: one input item per cycle unless the output register stalls; the
//   parse state and both CRC updates are combinational on the state registers.
//   Back-pressure: a single output register holds the pending result; in_ch
//   stays ready while that register is empty or is being emptied in the same
//   cycle, so a stalled receiver stalls the input after one pending result.
//   Reset: the parser returns to hunting for the start byte, CRCs go to their
//   seeds, held length and command id clear and the output register empties.
module referee_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    rfr_in_if.sink     in_ch,
    rfr_out_if.source  out_ch
);

    // Counter wide enough for the header position and any legal payload index
    localparam int unsigned PAY_W = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned CNT_W = (PAY_W > 3) ? PAY_W : 3;

    rfr_pkg::phase_t     phase_reg, phase_next;
    logic [CNT_W-1:0]    byte_count_reg, byte_count_next;
    logic [7:0]          header_crc_reg, header_crc_next;
    logic [15:0]         frame_crc_reg, frame_crc_next;
    logic [15:0]         length_hold_reg, length_hold_next;
    logic [15:0]         command_hold_reg, command_hold_next;
    logic [7:0]          tail_low_hold_reg, tail_low_hold_next;

    logic                out_valid_reg;
    rfr_pkg::kind_t      kind_reg, kind_next;
    logic [7:0]          pbyte_reg, pbyte_next;
    logic [7:0]          poff_reg, poff_next;
    logic [15:0]         cmd_reg, cmd_next;
    logic [15:0]         flen_reg, flen_next;
    rfr_pkg::status_t    status_reg, status_next;
    rfr_pkg::class_t     class_reg, class_next;

    logic                in_fire;
    logic                res_fire;
    logic [7:0]          b;
    logic [CNT_W-1:0]    cnt_inc;
    logic [15:0]         cnt_ext;
    logic [7:0]          hcrc_step;
    logic [15:0]         fcrc_step;

    // Accept while the output register is free or being emptied
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign b           = in_ch.rx_byte;
    assign cnt_inc     = byte_count_reg + CNT_W'(1);
    assign cnt_ext     = 16'(byte_count_reg);
    assign hcrc_step   = rfr_pkg::crc8_next(header_crc_reg, b);
    assign fcrc_step   = rfr_pkg::crc16_next(frame_crc_reg, b);

    // Parse one item: next state and the result it causes
    always_comb
    begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        header_crc_next    = header_crc_reg;
        frame_crc_next     = frame_crc_reg;
        length_hold_next   = length_hold_reg;
        command_hold_next  = command_hold_reg;
        tail_low_hold_next = tail_low_hold_reg;
        res_fire           = 1'b0;
        kind_next          = rfr_pkg::KIND_STATUS;
        pbyte_next         = 8'h00;
        poff_next          = 8'h00;
        cmd_next           = 16'h0000;
        flen_next          = length_hold_reg;
        status_next        = rfr_pkg::ST_OK;
        class_next         = rfr_pkg::CLS_OTHER;

        if (in_fire) begin
            if (in_ch.action == rfr_pkg::ACT_IDLE) begin
                phase_next      = rfr_pkg::PH_HUNT;
                byte_count_next = '0;
                header_crc_next = rfr_pkg::HDR_CRC_SEED;
                frame_crc_next  = rfr_pkg::CRC16_INIT;
            end
            else begin
                unique case (phase_reg)
                    rfr_pkg::PH_HEADER:
                    begin
                        if (byte_count_reg < CNT_W'(rfr_pkg::HDR_LAST)) begin
                            header_crc_next = hcrc_step;
                            frame_crc_next  = fcrc_step;
                            if (byte_count_reg == CNT_W'(1)) begin
                                length_hold_next = {8'h00, b};
                            end
                            else if (byte_count_reg == CNT_W'(2)) begin
                                length_hold_next = {b, length_hold_reg[7:0]};
                            end
                            byte_count_next = cnt_inc;
                        end
                        else if (b != header_crc_reg ||
                                 length_hold_reg > 16'(MAX_PAYLOAD)) begin
                            // Drop the frame with a header status
                            res_fire        = 1'b1;
                            status_next     = (b != header_crc_reg) ? rfr_pkg::ST_HDR_CRC
                                                                    : rfr_pkg::ST_LEN_LARGE;
                            phase_next      = rfr_pkg::PH_HUNT;
                            byte_count_next = '0;
                            header_crc_next = rfr_pkg::HDR_CRC_SEED;
                            frame_crc_next  = rfr_pkg::CRC16_INIT;
                        end
                        else begin
                            frame_crc_next  = fcrc_step;
                            phase_next      = rfr_pkg::PH_CMD;
                            byte_count_next = '0;
                        end
                    end

                    rfr_pkg::PH_CMD:
                    begin
                        frame_crc_next = fcrc_step;
                        if (byte_count_reg == '0) begin
                            command_hold_next = {8'h00, b};
                            byte_count_next   = CNT_W'(1);
                        end
                        else begin
                            command_hold_next = {b, command_hold_reg[7:0]};
                            byte_count_next   = '0;
                            phase_next        = (length_hold_reg == 16'h0000) ?
                                                rfr_pkg::PH_TAIL : rfr_pkg::PH_PAYLOAD;
                        end
                    end

                    rfr_pkg::PH_PAYLOAD:
                    begin
                        // Deliver the byte at once
                        frame_crc_next = fcrc_step;
                        res_fire       = 1'b1;
                        kind_next      = rfr_pkg::KIND_PAYLOAD;
                        pbyte_next     = b;
                        poff_next      = cnt_ext[7:0];
                        cmd_next       = command_hold_reg;
                        if (16'(cnt_inc) >= length_hold_reg) begin
                            byte_count_next = '0;
                            phase_next      = rfr_pkg::PH_TAIL;
                        end
                        else begin
                            byte_count_next = cnt_inc;
                        end
                    end

                    rfr_pkg::PH_TAIL:
                    begin
                        if (byte_count_reg == '0) begin
                            tail_low_hold_next = b;
                            byte_count_next    = CNT_W'(1);
                        end
                        else begin
                            res_fire = 1'b1;
                            cmd_next = command_hold_reg;
                            if (tail_low_hold_reg == frame_crc_reg[7:0] &&
                                b == frame_crc_reg[15:8]) begin
                                class_next = rfr_pkg::classify(command_hold_reg);
                            end
                            else begin
                                status_next = rfr_pkg::ST_TAIL_CRC;
                            end
                            phase_next      = rfr_pkg::PH_HUNT;
                            byte_count_next = '0;
                            header_crc_next = rfr_pkg::HDR_CRC_SEED;
                            frame_crc_next  = rfr_pkg::CRC16_INIT;
                        end
                    end

                    default:
                    begin
                        // Hunt for the start byte
                        phase_next      = rfr_pkg::PH_HUNT;
                        byte_count_next = '0;
                        header_crc_next = rfr_pkg::HDR_CRC_SEED;
                        frame_crc_next  = rfr_pkg::CRC16_INIT;
                        if (b == rfr_pkg::SOF_BYTE) begin
                            header_crc_next = rfr_pkg::crc8_next(rfr_pkg::HDR_CRC_SEED, b);
                            frame_crc_next  = rfr_pkg::crc16_next(rfr_pkg::CRC16_INIT, b);
                            phase_next      = rfr_pkg::PH_HEADER;
                            byte_count_next = CNT_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    // Hold the parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg         <= rfr_pkg::PH_HUNT;
            byte_count_reg    <= '0;
            header_crc_reg    <= rfr_pkg::HDR_CRC_SEED;
            frame_crc_reg     <= rfr_pkg::CRC16_INIT;
            length_hold_reg   <= 16'h0000;
            command_hold_reg  <= 16'h0000;
            tail_low_hold_reg <= 8'h00;
        end
        else begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            header_crc_reg    <= header_crc_next;
            frame_crc_reg     <= frame_crc_next;
            length_hold_reg   <= length_hold_next;
            command_hold_reg  <= command_hold_next;
            tail_low_hold_reg <= tail_low_hold_next;
        end
    end

    // Advance the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && res_fire) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire && res_fire) begin
            kind_reg   <= kind_next;
            pbyte_reg  <= pbyte_next;
            poff_reg   <= poff_next;
            cmd_reg    <= cmd_next;
            flen_reg   <= flen_next;
            status_reg <= status_next;
            class_reg  <= class_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.result_kind    = kind_reg;
    assign out_ch.payload_byte   = pbyte_reg;
    assign out_ch.payload_offset = poff_reg;
    assign out_ch.command_id     = cmd_reg;
    assign out_ch.frame_length   = flen_reg;
    assign out_ch.frame_status   = status_reg;
    assign out_ch.command_class  = class_reg;

`ifndef ASSERT_OFF
    // A class is only reported for a frame that passed every check
    a_class_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && class_reg != rfr_pkg::CLS_OTHER |->
            kind_reg == rfr_pkg::KIND_STATUS && status_reg == rfr_pkg::ST_OK)
        else $error("command class reported on a bad or payload item");

    // Payload items always carry a clean status
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == rfr_pkg::KIND_PAYLOAD |->
            status_reg == rfr_pkg::ST_OK)
        else $error("payload item with non-zero status");

    // Payload phase only with a checked, non-empty length
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rfr_pkg::PH_PAYLOAD |->
            length_hold_reg != 16'h0000 && length_hold_reg <= 16'(MAX_PAYLOAD)
            && 16'(byte_count_reg) < length_hold_reg)
        else $error("payload phase with bad length or count");

    // An empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty output register");
`endif

endmodule
